// ===== rtl/sdq_pkg.sv =====
// Shared types and constants for the sleep delta queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package sdq_pkg;

  // Fixed widths of the port fields.
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned PORT_ID_W = 8;

  // Request type codes on in_req_type.
  localparam logic REQ_SLEEP = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_QUEUED  = 3'd0,
    STAT_ZERO    = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_WOKEN   = 3'd3,
    STAT_NO_WAKE = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SHIFT,
    S_TK_DEC,
    S_TK_POP
  } sdq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    logic    walk_step;
    logic    ins_write;
    logic    shift_write;
    logic    dec_write;
    logic    pop;
    logic    cnt_inc;
    logic    emit;
    logic    emit_last;
    logic    emit_woken;
    status_t emit_status;
  } sdq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ticks_zero;
    logic cnt_empty;
    logic cnt_full;
    logic idx_at_cnt;
    logic remain_ge;
    logic head_le1;
    logic head_zero;
  } sdq_stat_t;

endpackage

// ===== rtl/sdq_ctrl.sv =====
// Controller state machine for the sleep delta queue.
// Depends on sdq_pkg; drives commands to sdq_datapath and reads its status.
module sdq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_req_type,
  input  sdq_pkg::sdq_stat_t stat,
  output sdq_pkg::sdq_cmd_t  cmd,
  output logic             busy
);
  import sdq_pkg::*;

  sdq_state_t state_r;
  sdq_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_status = STAT_QUEUED;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_req_type == REQ_TICK) begin
            if (stat.cnt_empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.emit_status = STAT_NO_WAKE;
            end else begin
              cmd.load_req = 1'b1;
              state_nxt    = S_TK_DEC;
            end
          end else if (stat.ticks_zero) begin
            cmd.emit        = 1'b1;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = STAT_ZERO;
          end else if (stat.cnt_full) begin
            cmd.emit        = 1'b1;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = STAT_FULL;
          end else begin
            cmd.load_req = 1'b1;
            state_nxt    = S_WALK;
          end
        end
      end
      // Walk from the head, passing entries while the remainder covers them.
      S_WALK: begin
        if (stat.idx_at_cnt) begin
          cmd.ins_write   = 1'b1;
          cmd.cnt_inc     = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = STAT_QUEUED;
          state_nxt       = S_IDLE;
        end else if (stat.remain_ge) begin
          cmd.walk_step = 1'b1;
        end else begin
          cmd.ins_write = 1'b1;
          state_nxt     = S_SHIFT;
        end
      end
      // Move the displaced entries one place toward the tail.
      S_SHIFT: begin
        cmd.shift_write = 1'b1;
        if (stat.idx_at_cnt) begin
          cmd.cnt_inc     = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = STAT_QUEUED;
          state_nxt       = S_IDLE;
        end
      end
      // Decrement the head; pop it if it reaches zero.
      S_TK_DEC: begin
        if (!stat.head_le1) begin
          cmd.dec_write   = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = STAT_NO_WAKE;
          state_nxt       = S_IDLE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_TK_POP;
        end
      end
      // Report the popped thread; keep popping while the new head is zero.
      S_TK_POP: begin
        cmd.emit        = 1'b1;
        cmd.emit_woken  = 1'b1;
        cmd.emit_status = STAT_WOKEN;
        if (!stat.cnt_empty && stat.head_zero) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

`ifndef SYNTHESIS
  // The last result of an item always returns the controller to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.emit_last |=> state_r == S_IDLE)
    else $error("controller not idle after last result");

  // New work is loaded only from idle.
  a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_req |-> state_r == S_IDLE && start)
    else $error("load outside idle");
`endif

endmodule

// ===== rtl/sdq_datapath.sv =====
// Datapath of the sleep delta queue: circular entry memory, walk registers,
// head pointer, entry count and the result register. Depends on sdq_pkg.
module sdq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [sdq_pkg::PORT_ID_W-1:0]     in_thread_id,
  input  logic [sdq_pkg::TICK_W-1:0]        in_sleep_ticks,
  input  sdq_pkg::sdq_cmd_t                 cmd,
  output sdq_pkg::sdq_stat_t                stat,
  output logic                              out_valid,
  output sdq_pkg::status_t                  out_status,
  output logic [sdq_pkg::PORT_ID_W-1:0]     out_woken_id,
  output logic                              out_last_result
);
  import sdq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = ID_BITS + TICK_W;

  // Entry memory, one word per entry: {thread id, delta}.
  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [EW-1:0] rdata_r;
  logic          mem_we;
  logic [EW-1:0] mem_wdata;

  logic [AW-1:0]     head_r, head_nxt, head_inc;
  logic [AW-1:0]     ptr_r, ptr_nxt, ptr_inc;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [TICK_W-1:0] remain_r, remain_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [EW-1:0]     carry_r, carry_nxt;
  logic [ID_BITS-1:0] pend_r, pend_nxt;
  logic [ID_BITS-1:0] id_in;
  logic [PORT_ID_W-1:0] pend_port;
  logic [ID_BITS-1:0] rd_id;
  logic [TICK_W-1:0] rd_delta;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [PORT_ID_W-1:0] out_woken_id_r;
  logic                 out_last_r;

  assign rd_id    = rdata_r[EW-1:TICK_W];
  assign rd_delta = rdata_r[TICK_W-1:0];

  // Id width conversion between the port and the stored id.
  for (genvar g = 0; g < ID_BITS; g++) begin : g_id_in
    if (g < PORT_ID_W) begin : g_bit
      assign id_in[g] = in_thread_id[g];
    end else begin : g_zero
      assign id_in[g] = 1'b0;
    end
  end
  for (genvar g = 0; g < PORT_ID_W; g++) begin : g_id_out
    if (g < ID_BITS) begin : g_bit
      assign pend_port[g] = pend_r[g];
    end else begin : g_zero
      assign pend_port[g] = 1'b0;
    end
  end

  // Wrapping increments of the circular pointers.
  assign head_inc = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign ptr_inc  = (ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : ptr_r + 1'b1;

  // Status toward the controller.
  always_comb begin
    stat.ticks_zero = (in_sleep_ticks == '0);
    stat.cnt_empty  = (count_r == '0);
    stat.cnt_full   = (count_r == CW'(QUEUE_DEPTH));
    stat.idx_at_cnt = (idx_r == count_r);
    stat.remain_ge  = (remain_r >= rd_delta);
    stat.head_le1   = (rd_delta[TICK_W-1:1] == '0);
    stat.head_zero  = (rd_delta == '0);
  end

  // Next values of the walk and queue registers.
  always_comb begin
    head_nxt   = head_r;
    ptr_nxt    = ptr_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    remain_nxt = remain_r;
    id_nxt     = id_r;
    carry_nxt  = carry_r;
    pend_nxt   = pend_r;
    mem_we     = 1'b0;
    mem_wdata  = {id_r, remain_r};
    if (cmd.load_req) begin
      ptr_nxt    = head_r;
      idx_nxt    = '0;
      remain_nxt = in_sleep_ticks;
      id_nxt     = id_in;
    end
    if (cmd.walk_step) begin
      remain_nxt = remain_r - rd_delta;
      idx_nxt    = idx_r + 1'b1;
      ptr_nxt    = ptr_inc;
    end
    if (cmd.ins_write) begin
      mem_we    = 1'b1;
      mem_wdata = {id_r, remain_r};
      carry_nxt = {rd_id, rd_delta - remain_r};
      idx_nxt   = idx_r + 1'b1;
      ptr_nxt   = ptr_inc;
    end
    if (cmd.shift_write) begin
      mem_we    = 1'b1;
      mem_wdata = carry_r;
      carry_nxt = rdata_r;
      idx_nxt   = idx_r + 1'b1;
      ptr_nxt   = ptr_inc;
    end
    if (cmd.dec_write) begin
      mem_we    = 1'b1;
      mem_wdata = {rd_id, rd_delta - 1'b1};
    end
    if (cmd.pop) begin
      pend_nxt  = rd_id;
      head_nxt  = head_inc;
      ptr_nxt   = head_inc;
      count_nxt = count_r - 1'b1;
    end
    if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end
  end

  // Entry memory: one write at the walk pointer, one registered read ahead.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr_r] <= mem_wdata;
    end
    rdata_r <= mem[ptr_nxt];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      ptr_r       <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    remain_r <= remain_nxt;
    id_r     <= id_nxt;
    carry_r  <= carry_nxt;
    pend_r   <= pend_nxt;
    if (cmd.emit) begin
      out_status_r   <= cmd.emit_status;
      out_woken_id_r <= cmd.emit_woken ? pend_port : '0;
      out_last_r     <= cmd.emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_woken_id    = out_woken_id_r;
  assign out_last_result = out_last_r;

`ifndef SYNTHESIS
  // The entry count never passes the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count out of range");

  // An insertion never completes on a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> count_r != CW'(QUEUE_DEPTH))
    else $error("insert into full queue");

  // A pop always removes an existing entry and moves the head by one.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> count_r != '0 ##1 count_r == $past(count_r) - 1'b1)
    else $error("pop from empty queue");

  // A result word carries a thread id only when it reports a wake-up.
  a_woken_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STAT_WOKEN |-> out_woken_id_r == '0)
    else $error("woken id set on non-wake result");
`endif

endmodule

// ===== rtl/sleep_delta_queue_core.sv =====
// Top level of the sleep delta queue: controller plus datapath.
// Depends on sdq_pkg, sdq_ctrl and sdq_datapath.
//
// Usage: a request word is taken at a rising edge with start high and busy
// low. in_req_type selects a sleep request (in_thread_id, in_sleep_ticks)
// or one timer tick. Each result word is shown for one cycle with out_valid
// high; out_last_result marks the final word of a request. The receiver
// cannot stall, so every word must be taken as it appears.
// Flow: a zero-tick sleep, a sleep on a full queue and a tick on an
// empty queue answer in the cycle after acceptance with busy never raised.
// A sleep walks the queue one entry per cycle through the single-port read
// of the entry memory, writes the new entry and shifts the displaced ones
// toward the tail with busy high; its result word appears as busy falls.
// A tick that wakes nothing answers from S_TK_DEC through the result
// register; one that wakes threads moves from S_TK_DEC to S_TK_POP, which
// gives one word per cycle, one per woken thread, with busy high in both.
// Reset clears the entry count, pointers and controller; the entry memory
// is not cleared and needs no clearing pass.
module sleep_delta_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [sdq_pkg::PORT_ID_W-1:0] in_thread_id,
  input  logic [sdq_pkg::TICK_W-1:0]    in_sleep_ticks,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [sdq_pkg::PORT_ID_W-1:0] out_woken_id,
  output logic                          out_last_result
);
  import sdq_pkg::*;

  sdq_cmd_t  cmd;
  sdq_stat_t stat;
  status_t   status_w;

  // Sequencing of each request.
  sdq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  // Queue storage and arithmetic.
  sdq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_thread_id    (in_thread_id),
    .in_sleep_ticks  (in_sleep_ticks),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (status_w),
    .out_woken_id    (out_woken_id),
    .out_last_result (out_last_result)
  );

  assign out_status = status_w;

endmodule

// ===== tb/sleep_delta_queue_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sleep_delta_queue_core: directed and random
// sleep and tick requests, checked word by word against a delta-list predictor.
// Depends on sdq_pkg and the sleep_delta_queue_core RTL only.
module sleep_delta_queue_core_tb;
  import sdq_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TAIL_WAIT  = 40;

  // One expected result word.
  typedef struct {
    status_t          status;
    logic [7:0]       woken_id;
    logic             last_result;
  } wake_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_req_type;
  logic [PORT_ID_W-1:0] in_thread_id;
  logic [TICK_W-1:0] in_sleep_ticks;
  logic out_valid;
  logic [2:0] out_status;
  logic [PORT_ID_W-1:0] out_woken_id;
  logic out_last_result;

  // Predictor state: a delta list of sleeping threads.
  logic [31:0] sleep_delta[DEPTH];
  logic [7:0] sleep_owner[DEPTH];
  int unsigned sleeper_count;

  // Result words still owed by the block, oldest first.
  wake_word_t pending_words[$];
  wake_word_t want;

  int errors;
  int words_sent;
  int ticks_sent;
  int words_checked;
  int woken_seen;
  int full_seen;
  int unsigned quiet_cycles;

  sleep_delta_queue_core #(
    .QUEUE_DEPTH(DEPTH),
    .ID_BITS(8)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_thread_id(in_thread_id),
    .in_sleep_ticks(in_sleep_ticks),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_woken_id(out_woken_id),
    .out_last_result(out_last_result)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void owe_word(status_t status, logic [7:0] id, logic last_result);
    wake_word_t w;
    w.status      = status;
    w.woken_id    = id;
    w.last_result = last_result;
    pending_words.push_back(w);
  endfunction

  // Apply one accepted request to the delta list and queue its result words.
  function automatic void predict_request(logic req, logic [7:0] id, logic [31:0] ticks);
    logic [31:0] remain;
    int unsigned pos;
    int woke;
    wake_word_t tail_word;
    if (req == REQ_TICK) begin
      if (sleeper_count == 0) begin
        owe_word(STAT_NO_WAKE, 8'd0, 1'b1);
      end else begin
        if (sleep_delta[0] != 0) sleep_delta[0] = sleep_delta[0] - 1;
        woke = 0;
        // Pop every head that has run out, in queue order.
        while (sleeper_count > 0 && sleep_delta[0] == 0) begin
          owe_word(STAT_WOKEN, sleep_owner[0], 1'b0);
          woke++;
          for (int i = 1; i < sleeper_count; i++) begin
            sleep_delta[i-1] = sleep_delta[i];
            sleep_owner[i-1] = sleep_owner[i];
          end
          sleeper_count--;
        end
        if (woke == 0) begin
          owe_word(STAT_NO_WAKE, 8'd0, 1'b1);
        end else begin
          tail_word = pending_words.pop_back();
          tail_word.last_result = 1'b1;
          pending_words.push_back(tail_word);
        end
      end
    end else if (ticks == 0) begin
      owe_word(STAT_ZERO, 8'd0, 1'b1);
    end else if (sleeper_count >= DEPTH) begin
      owe_word(STAT_FULL, 8'd0, 1'b1);
    end else begin
      // Walk past every entry that wakes no later than this one.
      remain = ticks;
      pos = 0;
      while (pos < sleeper_count && remain >= sleep_delta[pos]) begin
        remain = remain - sleep_delta[pos];
        pos++;
      end
      for (int i = sleeper_count; i > pos; i--) begin
        sleep_delta[i] = sleep_delta[i-1];
        sleep_owner[i] = sleep_owner[i-1];
      end
      sleep_delta[pos] = remain;
      sleep_owner[pos] = id;
      sleeper_count++;
      if (pos + 1 < sleeper_count) sleep_delta[pos+1] = sleep_delta[pos+1] - remain;
      owe_word(STAT_QUEUED, 8'd0, 1'b1);
    end
  endfunction

  // Offer one request word and hold it until the block takes it.
  task automatic send_word(logic req, logic [7:0] id, logic [31:0] ticks);
    start          <= 1'b1;
    in_req_type    <= req;
    in_thread_id   <= id;
    in_sleep_ticks <= ticks;
    do @(posedge clk); while (busy);
    predict_request(req, id, ticks);
    words_sent++;
    if (req == REQ_TICK) ticks_sent++;
  endtask

  // Random sender gaps; pct is the chance of idling in a given cycle.
  task automatic sender_gap(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off the sender until every owed word has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_and_zero();
    send_word(REQ_TICK, 8'h00, 32'd0);
    send_word(REQ_SLEEP, 8'h5A, 32'd0);
  endtask

  // Equal deadlines keep arrival order; an earlier one cuts in front.
  task automatic test_fill_and_order();
    send_word(REQ_SLEEP, 8'h00, 32'd2);
    send_word(REQ_SLEEP, 8'hFF, 32'd2);
    send_word(REQ_SLEEP, 8'h81, 32'd1);
    for (int k = 0; k < 13; k++) begin
      send_word(REQ_SLEEP, 8'h40 + 8'(k), 32'd2);
    end
  endtask

  // The zero check wins over the full check.
  task automatic test_full_queue();
    send_word(REQ_SLEEP, 8'h11, 32'd0);
    send_word(REQ_SLEEP, 8'h22, 32'd7);
  endtask

  task automatic test_wake_burst();
    send_word(REQ_TICK, 8'hA5, 32'hFFFF_FFFF);
    send_word(REQ_TICK, 8'h00, 32'd0);
  endtask

  // Deadlines at the top of the tick range never come due in this run.
  task automatic test_far_deadlines();
    send_word(REQ_SLEEP, 8'h3C, 32'hFFFF_FFFF);
    send_word(REQ_TICK, 8'h00, 32'd0);
    send_word(REQ_SLEEP, 8'hC3, 32'hFFFF_FFFE);
  endtask

  // Mostly short sleeps and ticks, so threads keep waking; a few zero and far
  // sleeps mixed in.
  task automatic test_random_traffic(int unsigned count, int unsigned idle_pct);
    int unsigned roll;
    logic [31:0] ticks;
    for (int unsigned n = 0; n < count; n++) begin
      sender_gap(idle_pct);
      if ($urandom_range(99) < 38) begin
        send_word(REQ_TICK, 8'($urandom), $urandom);
      end else begin
        roll = $urandom_range(99);
        if (roll < 5) ticks = 32'd0;
        else if (roll < 7) ticks = $urandom;
        else if (roll < 15) ticks = $urandom_range(60, 11);
        else ticks = $urandom_range(10, 1);
        send_word(REQ_SLEEP, 8'($urandom), ticks);
      end
    end
  endtask

  // Result checker: each strobed word against the oldest owed word.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $error("Unexpected result word: status %0d woken_id %0d last_result %0d",
               out_status, out_woken_id, out_last_result);
        errors++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_status == STAT_WOKEN) woken_seen++;
        if (out_status == STAT_FULL) full_seen++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_woken_id !== want.woken_id) begin
          $error("woken_id: expected %0d, got %0d", want.woken_id, out_woken_id);
          errors++;
        end
        if (out_last_result !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result, out_last_result);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
        $display("** sleep_delta_queue_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    errors        = 0;
    words_sent    = 0;
    ticks_sent    = 0;
    words_checked = 0;
    woken_seen    = 0;
    full_seen     = 0;
    quiet_cycles  = 0;
    sleeper_count = 0;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_req_type    <= REQ_SLEEP;
    in_thread_id   <= '0;
    in_sleep_ticks <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_and_zero();
    test_fill_and_order();
    test_full_queue();
    test_wake_burst();
    test_far_deadlines();
    drain_results();

    test_random_traffic(70, 0);
    drain_results();
    test_random_traffic(68, 78);
    drain_results();
    test_random_traffic(67, 33);

    // Let any stray words show up before the verdict.
    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Sent %0d requests (%0d ticks); checked %0d result words,",
             words_sent, ticks_sent, words_checked);
    $display("including %0d woken threads and %0d full-queue rejections.",
             woken_seen, full_seen);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("** sleep_delta_queue_core: PASSED **");
    end else begin
      $display("** sleep_delta_queue_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sleep_delta_queue_core.f =====
rtl/sdq_pkg.sv
rtl/sdq_ctrl.sv
rtl/sdq_datapath.sv
rtl/sleep_delta_queue_core.sv
tb/sleep_delta_queue_core_tb.sv
